// ----- rtl/crcrd_pkg.sv -----
// ----------------------------------------------------------------------------
// crcrd_pkg
// Shared types, constants and the bytewise CRC-32 update for the checked
// record decoder.
// ----------------------------------------------------------------------------
package crcrd_pkg;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [7:0]  TAG_RESET    = 8'd80;
	localparam logic [7:0]  CHAR_R       = 8'h52;
	localparam logic [7:0]  CHAR_H       = 8'h48;
	localparam logic [7:0]  CHAR_S       = 8'h53;
	localparam logic [7:0]  CHAR_A       = 8'h41;
	localparam logic [7:0]  CHAR_Z       = 8'h5A;
	localparam logic [7:0]  RECORD_VER   = 8'd1;

	localparam logic [3:0] POS_TAG     = 4'd0;
	localparam logic [3:0] POS_R       = 4'd1;
	localparam logic [3:0] POS_H       = 4'd2;
	localparam logic [3:0] POS_S       = 4'd3;
	localparam logic [3:0] POS_VER     = 4'd4;
	localparam logic [3:0] POS_SCORE0  = 4'd5;
	localparam logic [3:0] POS_SCORE1  = 4'd6;
	localparam logic [3:0] POS_SCORE2  = 4'd7;
	localparam logic [3:0] POS_SCORE3  = 4'd8;
	localparam logic [3:0] POS_INIT0   = 4'd9;
	localparam logic [3:0] POS_INIT1   = 4'd10;
	localparam logic [3:0] POS_INIT2   = 4'd11;
	localparam logic [3:0] POS_CRC0    = 4'd12;
	localparam logic [3:0] POS_LAST    = 4'd15;

	typedef struct packed {
		logic        record_valid;
		logic [31:0] score;
		logic [6:0]  initial_first;
		logic [6:0]  initial_second;
		logic [6:0]  initial_third;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/crc_checked_record_decoder_core.sv -----
// ----------------------------------------------------------------------------
// crc_checked_record_decoder_core
// Decodes and checks 16-byte score records with a trailing CRC-32.
// ----------------------------------------------------------------------------
// The block takes one record byte per cycle with no gaps of its own. A byte
// is registered, then checked and folded into the running CRC from that
// register; that bytewise CRC update sets the clock budget. The result of a
// record is formed when its sixteenth byte leaves the byte register and is
// held in an output register, so input keeps flowing while a result waits
// to be taken; only the last byte of the next record waits for it.
module crc_checked_record_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  record_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        record_valid,
	output logic [31:0] score,
	output logic [6:0]  initial_first,
	output logic [6:0]  initial_second,
	output logic [6:0]  initial_third,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  game_tag
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic [7:0]         tag_q;
	logic               out_valid_q;
	crcrd_pkg::result_t out_q;
	crcrd_pkg::result_t result;
	logic               last;
	logic               out_free;
	logic               adv_s1;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign adv_s1    = valid_s1 && (!last || out_free);
	assign in_ready  = !valid_s1 || adv_s1;

	crcrd_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.record_byte (byte_s1),
		.game_tag    (tag_q),
		.last        (last),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= crcrd_pkg::TAG_RESET;
		end else if (cfg_valid) begin
			tag_q <= game_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= record_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign record_valid   = out_q.record_valid;
	assign score          = out_q.score;
	assign initial_first  = out_q.initial_first;
	assign initial_second = out_q.initial_second;
	assign initial_third  = out_q.initial_third;

endmodule

// ----- rtl/crcrd_check.sv -----
// ----------------------------------------------------------------------------
// crcrd_check
// Per-record state: byte position, running CRC, check flag, score and
// initials. Checks one byte per step and forms the result on the last byte.
// ----------------------------------------------------------------------------
module crcrd_check (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              record_byte,
	input  logic [7:0]              game_tag,
	output logic                    last,
	output crcrd_pkg::result_t      result
);

	logic [3:0]  pos_q;
	logic [31:0] crc_q;
	logic        pass_q;
	logic [31:0] score_q;
	logic [6:0]  init_q [3];
	logic        ok;
	logic        passed;
	logic [31:0] crc_fin;
	logic [7:0]  crc_want;

	assign crc_fin = crc_q ^ crcrd_pkg::CRC_ALL_ONES;

	always_comb begin
		case (pos_q[1:0])
			2'd0:    crc_want = crc_fin[7:0];
			2'd1:    crc_want = crc_fin[15:8];
			2'd2:    crc_want = crc_fin[23:16];
			default: crc_want = crc_fin[31:24];
		endcase
	end

	always_comb begin
		case (pos_q)
			crcrd_pkg::POS_TAG: ok = (record_byte == game_tag);
			crcrd_pkg::POS_R:   ok = (record_byte == crcrd_pkg::CHAR_R);
			crcrd_pkg::POS_H:   ok = (record_byte == crcrd_pkg::CHAR_H);
			crcrd_pkg::POS_S:   ok = (record_byte == crcrd_pkg::CHAR_S);
			crcrd_pkg::POS_VER: ok = (record_byte == crcrd_pkg::RECORD_VER);
			crcrd_pkg::POS_SCORE0, crcrd_pkg::POS_SCORE1,
			crcrd_pkg::POS_SCORE2, crcrd_pkg::POS_SCORE3: ok = 1'b1;
			crcrd_pkg::POS_INIT0, crcrd_pkg::POS_INIT1, crcrd_pkg::POS_INIT2: begin
				ok = (record_byte inside {[crcrd_pkg::CHAR_A : crcrd_pkg::CHAR_Z]});
			end
			default: ok = (record_byte == crc_want);
		endcase
	end

	assign last   = (pos_q == crcrd_pkg::POS_LAST);
	assign passed = pass_q & ok;

	always_comb begin
		result.record_valid   = passed;
		result.score          = passed ? score_q : 32'd0;
		result.initial_first  = passed ? init_q[0] : 7'd0;
		result.initial_second = passed ? init_q[1] : 7'd0;
		result.initial_third  = passed ? init_q[2] : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= crcrd_pkg::POS_TAG;
			crc_q   <= crcrd_pkg::CRC_ALL_ONES;
			pass_q  <= 1'b1;
			score_q <= 32'd0;
		end else if (step) begin
			if (last) begin
				pos_q   <= crcrd_pkg::POS_TAG;
				crc_q   <= crcrd_pkg::CRC_ALL_ONES;
				pass_q  <= 1'b1;
				score_q <= 32'd0;
			end else begin
				pos_q  <= pos_q + 4'd1;
				pass_q <= passed;
				if (pos_q < crcrd_pkg::POS_CRC0) begin
					crc_q <= crcrd_pkg::crc_byte(crc_q, record_byte);
				end
				case (pos_q)
					crcrd_pkg::POS_SCORE0: score_q[7:0]   <= record_byte;
					crcrd_pkg::POS_SCORE1: score_q[15:8]  <= record_byte;
					crcrd_pkg::POS_SCORE2: score_q[23:16] <= record_byte;
					crcrd_pkg::POS_SCORE3: score_q[31:24] <= record_byte;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			case (pos_q)
				crcrd_pkg::POS_INIT0: init_q[0] <= record_byte[6:0];
				crcrd_pkg::POS_INIT1: init_q[1] <= record_byte[6:0];
				crcrd_pkg::POS_INIT2: init_q[2] <= record_byte[6:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/crcrd_checker.sv -----
// ----------------------------------------------------------------------------
// crcrd_checker
// Port-level assertions for the checked record decoder, bound to the top.
// ----------------------------------------------------------------------------
module crcrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        record_valid,
	input logic [31:0] score,
	input logic [6:0]  initial_first,
	input logic [6:0]  initial_second,
	input logic [6:0]  initial_third
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_valid) && $stable(score)
			&& $stable(initial_first) && $stable(initial_second) && $stable(initial_third))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_valid |-> score == 32'd0 && initial_first == 7'd0
			&& initial_second == 7'd0 && initial_third == 7'd0)
		else $error("invalid record carries nonzero fields");

	a_valid_letters: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_valid |->
			initial_first >= 7'h41 && initial_first <= 7'h5A
			&& initial_second >= 7'h41 && initial_second <= 7'h5A
			&& initial_third >= 7'h41 && initial_third <= 7'h5A)
		else $error("valid record with initials outside A to Z");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a byte accepted two cycles before");

endmodule

bind crc_checked_record_decoder_core crcrd_checker u_crcrd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.record_valid   (record_valid),
	.score          (score),
	.initial_first  (initial_first),
	.initial_second (initial_second),
	.initial_third  (initial_third)
);
